### rtl/core/multi_stream_stop_and_wait_arq_core_assert.svh
// assertion macros shared by the core modules
`ifndef MULTI_STREAM_STOP_AND_WAIT_ARQ_CORE_ASSERT_SVH
`define MULTI_STREAM_STOP_AND_WAIT_ARQ_CORE_ASSERT_SVH

// implication checked on every edge outside reset
`define ARQ_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("arq check failed");

// implication checked in the cycle after the premise
`define ARQ_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("arq check failed");

`endif

### rtl/core/arq_pkg.sv
`default_nettype none
package arq_pkg;

  localparam int unsigned TagW  = 16;
  localparam int unsigned CtrW  = 16;
  localparam int unsigned TimeW = 64;
  localparam int unsigned StrW  = 3;
  localparam int unsigned TmoW  = 16;
  localparam int unsigned CfgW  = 15;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgW-1:0] BaseReset = 15'd1500;
  localparam logic [CfgW-1:0] CapReset  = 15'd6000;

  typedef enum logic [1:0] {
    ACT_UNREL = 2'd0,
    ACT_QUEUE = 2'd1,
    ACT_RCPT  = 2'd2,
    ACT_TICK  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RES_TX_UNREL = 2'd0,
    RES_TX_REL   = 2'd1,
    RES_RESP     = 2'd2,
    RES_REPORT   = 2'd3
  } result_e;

  typedef enum logic [2:0] {
    RK_OK      = 3'd0,
    RK_PKT_ERR = 3'd1,
    RK_PAY_ERR = 3'd2,
    RK_CORR    = 3'd3
  } rkind_e;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_BAD_TYPE  = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_MISMATCH  = 3'd3,
    ST_OUTDATED  = 3'd4,
    ST_CORRECTED = 3'd5,
    ST_FULL      = 3'd6
  } status_e;

  localparam logic [0:0] CFG_BASE = 1'b0;
  localparam logic [0:0] CFG_CAP  = 1'b1;

  typedef struct packed {
    logic [1:0]       action;
    logic [StrW-1:0]  stream;
    logic [TagW-1:0]  request_tag;
    logic [TimeW-1:0] stamp_time;
    logic [2:0]       receipt_kind;
    logic [CtrW-1:0]  receipt_counter;
    logic [CtrW-1:0]  corrected_counter;
    logic             stamp_valid;
  } in_item_t;

  typedef struct packed {
    logic [1:0]       result_kind;
    logic [StrW-1:0]  out_stream;
    logic [TagW-1:0]  out_tag;
    logic [CtrW-1:0]  out_counter;
    logic [TimeW-1:0] out_time;
    logic [1:0]       response_kind;
    logic [2:0]       status_code;
    logic             last;
  } out_item_t;

endpackage
`default_nettype wire

### rtl/core/multi_stream_stop_and_wait_arq_core.sv
// Multi-stream stop-and-wait uplink engine.
// Items enter on start/item_i when busy is low. Configuration writes
// (cfg_we_i, cfg_idx_i, cfg_data_i) must go in only while the block is idle,
// which the block does not enforce. Index 0 is base timeout, index 1 timeout cap.
// Each result appears on result_o for one cycle with valid_o high; the
// final result of an item has last set. The receiver cannot stall.
// Send, queue and receipt results pass the READ and EXEC states and are
// registered onto result_o; a receipt that moves to the next head adds the
// SEND and TSEND states for the follow-on transmit. A tick scans all streams
// at once, then passes SEND and TSEND for each retransmitting stream.
// The engine takes no new item until it is back in idle; the one-entry
// hand-off queue takes the next item while the engine works.
// Reset clears counters and queues and loads the reset timeouts; no
// clearing pass is needed since queue entries are read only once written.
`default_nettype none
module multi_stream_stop_and_wait_arq_core
  import arq_pkg::*;
#(
  parameter int unsigned NUM_STREAMS = 5,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           item_i,
  output logic                    valid_o,
  output out_item_t               result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);
  logic [CfgW-1:0] base_q, cap_q;
  logic back_busy, push, front_busy;
  in_item_t qitem;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BaseReset;
      cap_q  <= CapReset;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_BASE) base_q <= cfg_data_i;
      else cap_q <= cfg_data_i;
    end
  end

  assign busy = front_busy;

  arq_front #(.NumStreams(NUM_STREAMS)) u_front (
    .clk_i, .rst_ni, .start_i(start), .item_i, .back_busy_i(back_busy),
    .busy_o(front_busy), .push_o(push), .item_o(qitem));

  arq_back #(.NumStreams(NUM_STREAMS), .QueueDepth(QUEUE_DEPTH)) u_back (
    .clk_i, .rst_ni, .base_i(base_q), .cap_i(cap_q), .push_i(push),
    .item_i(qitem), .busy_o(back_busy), .valid_o, .result_o);
endmodule
`default_nettype wire

### rtl/core/arq_ram.sv
`default_nettype none
module arq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // one write port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

### rtl/core/arq_front.sv
`default_nettype none
module arq_front
  import arq_pkg::*;
#(
  parameter int unsigned NumStreams = 5
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start_i,
  input  wire in_item_t item_i,
  input  wire logic     back_busy_i,
  output logic          busy_o,
  output logic          push_o,
  output in_item_t      item_o
);
  logic     full_q;
  in_item_t hold_q;

  // single-entry queue between decode side and engine
  assign busy_o = full_q;
  assign push_o = full_q && !back_busy_i;
  assign item_o = hold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (start_i && !full_q) begin
      // drop items with no effect: out-of-range stream on a non-tick
      full_q <= (item_i.action == ACT_TICK) ||
                ({1'b0, item_i.stream} < (StrW+1)'(NumStreams));
    end else if (push_o) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !full_q) begin
      hold_q <= item_i;
    end
  end

  `include "multi_stream_stop_and_wait_arq_core_assert.svh"
  `ARQ_ASSERT_NEXT(a_hold_stable, clk_i, rst_ni, full_q && !push_o, full_q)
  `ARQ_ASSERT_IMP(a_push_full, clk_i, rst_ni, push_o, full_q)
  `ARQ_ASSERT_IMP(a_busy_full, clk_i, rst_ni, busy_o, full_q)
endmodule
`default_nettype wire

### rtl/core/arq_back.sv
`default_nettype none
module arq_back
  import arq_pkg::*;
#(
  parameter int unsigned NumStreams = 5,
  parameter int unsigned QueueDepth = 16
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [CfgW-1:0] base_i,
  input  wire logic [CfgW-1:0] cap_i,
  input  wire logic            push_i,
  input  wire in_item_t        item_i,
  output logic                 busy_o,
  output logic                 valid_o,
  output out_item_t            result_o
);
  localparam int unsigned SW   = (NumStreams > 1) ? $clog2(NumStreams) : 1;
  localparam int unsigned QW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW   = $clog2(QueueDepth + 1);
  localparam int unsigned MD   = NumStreams * QueueDepth;
  localparam int unsigned AW   = $clog2(MD);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_READ  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_SEND  = 6'b001000,
    S_TICK  = 6'b010000,
    S_TSEND = 6'b100000
  } state_e;

  state_e state_q, state_d;
  in_item_t it_q;
  logic [SW-1:0] s_q;
  logic [CtrW-1:0] rel_q [NumStreams];
  logic [CtrW-1:0] unr_q [NumStreams];
  logic [TmoW-1:0] tmo_q [NumStreams];
  logic [TmoW-1:0] cnt_q [NumStreams];
  logic [QW-1:0]   head_q [NumStreams];
  logic [CW-1:0]   qcnt_q [NumStreams];
  logic [NumStreams-1:0] fire_q;
  logic            qfull_q;

  // pending queue storage
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [TagW-1:0] rtag;
  logic [TimeW-1:0] rtime;

  function automatic logic [AW-1:0] addr_of(logic [SW-1:0] s, logic [QW-1:0] p);
    addr_of = AW'(s) * AW'(QueueDepth) + AW'(p);
  endfunction

  arq_ram #(.Width(TagW), .Depth(MD)) u_tags (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(item_i.request_tag),
    .raddr_i(raddr), .rdata_o(rtag));
  arq_ram #(.Width(TimeW), .Depth(MD)) u_times (
    .clk_i(clk_i), .we_i(we), .waddr_i(waddr), .wdata_i(item_i.stamp_time),
    .raddr_i(raddr), .rdata_o(rtime));

  logic [SW-1:0] in_s;
  logic [CW:0]   tsum;
  logic [QW-1:0] tail;
  logic          in_full;
  assign in_s    = item_i.stream[SW-1:0];
  // tail slot wraps at the queue depth
  assign tsum    = (CW+1)'(head_q[in_s]) + (CW+1)'(qcnt_q[in_s]);
  assign tail    = QW'((tsum >= (CW+1)'(QueueDepth)) ? tsum - (CW+1)'(QueueDepth) : tsum);
  assign in_full = qcnt_q[in_s] >= CW'(QueueDepth);
  assign we      = push_i && (item_i.action == ACT_QUEUE) && !in_full;
  assign waddr   = addr_of(in_s, tail);
  assign raddr   = addr_of(s_q, head_q[s_q]);

  // tick scan: next firing stream
  logic [SW-1:0] fnext;
  logic          fany;
  always_comb begin
    fnext = '0;
    fany  = 1'b0;
    for (int i = NumStreams - 1; i >= 0; i--) begin
      if (fire_q[i]) begin
        fnext = SW'(i);
        fany  = 1'b1;
      end
    end
  end
  logic [NumStreams-1:0] fire_rest;
  always_comb begin
    fire_rest = fire_q;
    fire_rest[fnext] = 1'b0;
  end

  assign busy_o = (state_q != S_IDLE);

  // result assembly
  out_item_t res_d;
  logic      val_d;
  logic      arm;
  logic      pop_set;
  logic [CtrW-1:0] cur_rel;
  assign cur_rel = rel_q[s_q];

  always_comb begin
    state_d = state_q;
    res_d   = '0;
    val_d   = 1'b0;
    arm     = 1'b0;
    pop_set = 1'b0;
    res_d.out_stream = StrW'(s_q);
    res_d.out_tag    = it_q.request_tag;
    res_d.out_time   = it_q.stamp_time;
    res_d.out_counter = it_q.receipt_counter;
    res_d.result_kind = RES_REPORT;
    unique case (state_q)
      S_IDLE: begin
        if (push_i) state_d = (item_i.action == ACT_TICK) ? S_TICK : S_READ;
      end
      S_READ: state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_IDLE;
        val_d   = 1'b1;
        res_d.last = 1'b1;
        case (it_q.action)
          ACT_UNREL: begin
            res_d.result_kind = RES_TX_UNREL;
            res_d.out_counter = unr_q[s_q];
          end
          ACT_QUEUE: begin
            if (qfull_q) begin
              res_d.status_code = ST_FULL;
            end else if (qcnt_q[s_q] == CW'(1)) begin
              res_d.result_kind = RES_TX_REL;
              res_d.out_tag = rtag;
              res_d.out_time = rtime;
              res_d.out_counter = cur_rel;
              arm = 1'b1;
            end else begin
              val_d = 1'b0;
            end
          end
          default: begin
            if (qcnt_q[s_q] == '0) begin
              res_d.status_code = ST_EMPTY;
            end else if (it_q.receipt_kind == RK_OK || it_q.receipt_kind == RK_PKT_ERR ||
                         it_q.receipt_kind == RK_PAY_ERR) begin
              if (it_q.receipt_counter != cur_rel) begin
                res_d.status_code = ST_MISMATCH;
              end else begin
                res_d.result_kind = RES_RESP;
                res_d.out_tag = rtag;
                res_d.response_kind = it_q.receipt_kind[1:0];
                pop_set = 1'b1;
                res_d.last = (qcnt_q[s_q] == CW'(1));
                if (qcnt_q[s_q] != CW'(1)) state_d = S_SEND;
              end
            end else if (it_q.receipt_kind == RK_CORR) begin
              res_d.out_counter = it_q.corrected_counter;
              if (it_q.stamp_valid && rtime != it_q.stamp_time) begin
                res_d.status_code = ST_OUTDATED;
              end else if (it_q.corrected_counter != cur_rel) begin
                res_d.status_code = ST_CORRECTED;
                res_d.last = 1'b0;
                state_d = S_SEND;
              end else begin
                val_d = 1'b0;
              end
            end else begin
              res_d.status_code = ST_BAD_TYPE;
            end
          end
        endcase
      end
      S_SEND: begin
        // read of the new head (after pop, correction or tick pick) is issued here
        state_d = S_TSEND;
      end
      S_TICK: begin
        if (fany) state_d = S_SEND;
        else state_d = S_IDLE;
      end
      S_TSEND: begin
        val_d = 1'b1;
        res_d.result_kind = RES_TX_REL;
        res_d.out_tag = rtag;
        res_d.out_time = rtime;
        res_d.out_counter = cur_rel;
        res_d.last = (it_q.action != ACT_TICK) || (fire_q == '0);
        arm = 1'b1;
        state_d = ((it_q.action == ACT_TICK) && (fire_q != '0)) ? S_SEND : S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // engine and per-stream state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_o <= 1'b0;
      s_q     <= '0;
      fire_q  <= '0;
      qfull_q <= 1'b0;
      for (int i = 0; i < NumStreams; i++) begin
        rel_q[i]  <= '0;
        unr_q[i]  <= '0;
        tmo_q[i]  <= TmoW'(BaseReset);
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        qcnt_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      valid_o <= val_d;
      if (state_q == S_IDLE && push_i) begin
        // a tick may carry any stream index, so keep the last valid one
        if (item_i.action != ACT_TICK) s_q <= in_s;
        // refused push is remembered for the exec step
        qfull_q <= (item_i.action == ACT_QUEUE) && in_full;
        if (item_i.action == ACT_QUEUE) begin
          if (!in_full) qcnt_q[in_s] <= qcnt_q[in_s] + CW'(1);
        end else if (item_i.action == ACT_TICK) begin
          for (int i = 0; i < NumStreams; i++) begin
            if (cnt_q[i] != '0) begin
              cnt_q[i] <= cnt_q[i] - TmoW'(1);
              fire_q[i] <= (cnt_q[i] == TmoW'(1)) && (qcnt_q[i] != '0);
            end else begin
              fire_q[i] <= 1'b0;
            end
          end
        end
      end
      // unreliable counter advances after its transmit
      if (state_q == S_EXEC && it_q.action == ACT_UNREL) begin
        unr_q[s_q] <= unr_q[s_q] + CtrW'(1);
      end
      if (state_q == S_TICK && fany) begin
        s_q    <= fnext;
        fire_q <= fire_rest;
      end
      if (state_q == S_TSEND && it_q.action == ACT_TICK && fire_q != '0) begin
        s_q    <= fnext;
        fire_q <= fire_rest;
      end
      if (pop_set) begin
        rel_q[s_q]  <= (it_q.receipt_kind == RK_OK) ? cur_rel + CtrW'(1) : cur_rel;
        tmo_q[s_q]  <= TmoW'(base_i);
        head_q[s_q] <= (head_q[s_q] == QW'(QueueDepth - 1)) ? '0 : head_q[s_q] + QW'(1);
        qcnt_q[s_q] <= qcnt_q[s_q] - CW'(1);
        if (qcnt_q[s_q] == CW'(1)) cnt_q[s_q] <= '0;
      end
      if (state_q == S_EXEC && res_d.status_code == ST_CORRECTED) begin
        rel_q[s_q] <= it_q.corrected_counter;
        tmo_q[s_q] <= TmoW'(base_i);
      end
      if (arm) begin
        cnt_q[s_q] <= (tmo_q[s_q] != '0) ? tmo_q[s_q] : TmoW'(1);
        if (tmo_q[s_q] < TmoW'(cap_i)) tmo_q[s_q] <= {tmo_q[s_q][TmoW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && push_i) it_q <= item_i;
    result_o <= res_d;
  end

  `include "multi_stream_stop_and_wait_arq_core_assert.svh"
  `ARQ_ASSERT_IMP(a_push_idle, clk_i, rst_ni, push_i, state_q == S_IDLE)
  `ARQ_ASSERT_IMP(a_qcnt_range, clk_i, rst_ni, 1'b1, qcnt_q[s_q] <= CW'(QueueDepth))
  `ARQ_ASSERT_NEXT(a_send_read, clk_i, rst_ni, state_q == S_SEND, state_q == S_TSEND)
endmodule
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
module tb;
  import arq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NS = 5;
  localparam int unsigned QD = 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_item_t item_i = '0;
  logic valid_o;
  out_item_t result_o;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0] cfg_data_i = '0;

  multi_stream_stop_and_wait_arq_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .valid_o(valid_o), .result_o(result_o), .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // engine state mirror
  logic [CfgW-1:0] base_tmo, cap_tmo;
  logic [15:0] rel_ctr[NS];
  logic [15:0] unrel_ctr[NS];
  logic [15:0] tmo_val[NS];
  logic [15:0] retry_cnt[NS];
  logic [15:0] q_tag[NS][QD];
  logic [63:0] q_time[NS][QD];
  int unsigned q_head[NS];
  int unsigned q_cnt[NS];

  out_item_t expected_q[$];
  in_item_t pending_items[$];
  int errors = 0;
  int n_out;

  task automatic push_out(input result_e k, input int unsigned s, input logic [15:0] tag,
                          input logic [15:0] ctr, input logic [63:0] t,
                          input logic [1:0] resp, input status_e st);
    out_item_t o;
    o.result_kind = k;
    o.out_stream = s[2:0];
    o.out_tag = tag;
    o.out_counter = ctr;
    o.out_time = t;
    o.response_kind = resp;
    o.status_code = st;
    o.last = 1'b0;
    expected_q.push_back(o);
    n_out++;
  endtask

  task automatic transmit_head(input int unsigned s);
    int unsigned h;
    if (q_cnt[s] == 0) begin
      retry_cnt[s] = '0;
      return;
    end
    h = q_head[s];
    push_out(RES_TX_REL, s, q_tag[s][h], rel_ctr[s], q_time[s][h], 2'd0, ST_NONE);
    retry_cnt[s] = (tmo_val[s] != 0) ? tmo_val[s] : 16'd1;
    if (32'(tmo_val[s]) < 32'(cap_tmo)) tmo_val[s] = tmo_val[s] * 16'd2;
  endtask

  task automatic predict_item(input in_item_t it);
    int unsigned s;
    int unsigned e;
    n_out = 0;
    s = it.stream;
    if (it.action == ACT_TICK) begin
      for (int i = 0; i < NS; i++) begin
        if (retry_cnt[i] == 0) continue;
        retry_cnt[i]--;
        if (retry_cnt[i] == 0 && q_cnt[i] != 0) transmit_head(i);
      end
    end else if (s < NS) begin
      if (it.action == ACT_UNREL) begin
        push_out(RES_TX_UNREL, s, it.request_tag, unrel_ctr[s], it.stamp_time, 2'd0, ST_NONE);
        unrel_ctr[s]++;
      end else if (it.action == ACT_QUEUE) begin
        if (q_cnt[s] >= QD) begin
          push_out(RES_REPORT, s, it.request_tag, it.receipt_counter, it.stamp_time,
                   2'd0, ST_FULL);
        end else begin
          e = (q_head[s] + q_cnt[s]) % QD;
          q_tag[s][e] = it.request_tag;
          q_time[s][e] = it.stamp_time;
          q_cnt[s]++;
          if (q_cnt[s] == 1) transmit_head(s);
        end
      end else if (q_cnt[s] == 0) begin
        push_out(RES_REPORT, s, it.request_tag, it.receipt_counter, it.stamp_time,
                 2'd0, ST_EMPTY);
      end else if (it.receipt_kind <= RK_PAY_ERR) begin
        if (it.receipt_counter != rel_ctr[s]) begin
          push_out(RES_REPORT, s, it.request_tag, it.receipt_counter, it.stamp_time,
                   2'd0, ST_MISMATCH);
        end else begin
          if (it.receipt_kind == RK_OK) rel_ctr[s]++;
          tmo_val[s] = 16'(base_tmo);
          push_out(RES_RESP, s, q_tag[s][q_head[s]], it.receipt_counter, it.stamp_time,
                   it.receipt_kind[1:0], ST_NONE);
          q_head[s] = (q_head[s] + 1) % QD;
          q_cnt[s]--;
          transmit_head(s);
        end
      end else if (it.receipt_kind == RK_CORR) begin
        if (it.stamp_valid && q_time[s][q_head[s]] != it.stamp_time) begin
          push_out(RES_REPORT, s, it.request_tag, it.corrected_counter, it.stamp_time,
                   2'd0, ST_OUTDATED);
        end else if (it.corrected_counter != rel_ctr[s]) begin
          push_out(RES_REPORT, s, it.request_tag, it.corrected_counter, it.stamp_time,
                   2'd0, ST_CORRECTED);
          rel_ctr[s] = it.corrected_counter;
          tmo_val[s] = 16'(base_tmo);
          transmit_head(s);
        end
      end else begin
        push_out(RES_REPORT, s, it.request_tag, it.receipt_counter, it.stamp_time,
                 2'd0, ST_BAD_TYPE);
      end
    end
    if (n_out > 0) expected_q[expected_q.size() - 1].last = 1'b1;
  endtask

  // driver: one transfer per pending item, with a random gap
  int gap_cnt = 0;
  always @(posedge clk_i) begin
    int gap;
    if (rst_ni) begin
      if (start && !busy) begin
        predict_item(item_i);
        pending_items.delete(0);
        gap = $urandom_range(0, 5);
        if (gap == 0 && pending_items.size() > 0) begin
          item_i <= pending_items[0];
        end else begin
          start <= 1'b0;
          gap_cnt <= (gap > 0) ? gap - 1 : 0;
        end
      end else if (!start) begin
        if (gap_cnt > 0) gap_cnt <= gap_cnt - 1;
        else if (pending_items.size() > 0) begin
          start <= 1'b1;
          item_i <= pending_items[0];
        end
      end
    end
  end

  // monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && valid_o) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result kind=%0d stream=%0d", result_o.result_kind,
               result_o.out_stream);
        errors++;
      end else begin
        e = expected_q[0];
        expected_q.delete(0);
        if (result_o.result_kind !== e.result_kind) begin
          $error("result_kind exp %0d got %0d", e.result_kind, result_o.result_kind);
          errors++;
        end
        if (result_o.out_stream !== e.out_stream) begin
          $error("out_stream exp %0d got %0d", e.out_stream, result_o.out_stream);
          errors++;
        end
        if (result_o.out_tag !== e.out_tag) begin
          $error("out_tag exp %0h got %0h", e.out_tag, result_o.out_tag);
          errors++;
        end
        if (result_o.out_counter !== e.out_counter) begin
          $error("out_counter exp %0h got %0h", e.out_counter, result_o.out_counter);
          errors++;
        end
        if (result_o.out_time !== e.out_time) begin
          $error("out_time exp %0h got %0h", e.out_time, result_o.out_time);
          errors++;
        end
        if (result_o.response_kind !== e.response_kind) begin
          $error("response_kind exp %0d got %0d", e.response_kind, result_o.response_kind);
          errors++;
        end
        if (result_o.status_code !== e.status_code) begin
          $error("status_code exp %0d got %0d", e.status_code, result_o.status_code);
          errors++;
        end
        if (result_o.last !== e.last) begin
          $error("last exp %0d got %0d", e.last, result_o.last);
          errors++;
        end
      end
    end
  end

  // stimulus helpers
  logic [63:0] last_stamp[NS];

  function automatic in_item_t noise_item();
    in_item_t it;
    it.action = 2'($urandom_range(0, 3));
    it.stream = 3'($urandom_range(0, 7));
    it.request_tag = 16'($urandom);
    it.stamp_time = {$urandom, $urandom};
    it.receipt_kind = 3'($urandom_range(0, 7));
    it.receipt_counter = 16'($urandom);
    it.corrected_counter = 16'($urandom);
    it.stamp_valid = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_item(input action_e a, input int unsigned s,
                                         input rkind_e rk, input logic [15:0] rc);
    in_item_t it;
    it = noise_item();
    it.action = a;
    it.stream = 3'(s);
    it.receipt_kind = rk;
    it.receipt_counter = rc;
    return it;
  endfunction

  task automatic add(input in_item_t it);
    if (it.action == ACT_QUEUE && it.stream < NS) last_stamp[it.stream] = it.stamp_time;
    pending_items.push_back(it);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || start || expected_q.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BASE) base_tmo = val;
    else cap_tmo = val;
  endtask

  // random phase: mostly well-formed traffic per stream
  task automatic random_phase(input int count);
    in_item_t it;
    int unsigned s;
    int r;
    for (int i = 0; i < count; i++) begin
      s = $urandom_range(0, NS - 1);
      r = $urandom_range(0, 99);
      if (r < 10) it = noise_item();
      else if (r < 20) it = make_item(ACT_UNREL, s, RK_OK, '0);
      else if (r < 42) it = make_item(ACT_QUEUE, s, RK_OK, '0);
      else if (r < 62) it = make_item(ACT_RCPT, s, rkind_e'($urandom_range(0, 2)),
                                      (r < 59) ? rel_ctr[s] : 16'($urandom));
      else if (r < 72) begin
        it = make_item(ACT_RCPT, s, RK_CORR, '0);
        it.corrected_counter = ($urandom_range(0, 3) == 0) ? rel_ctr[s] : 16'($urandom);
        if ($urandom_range(0, 1)) it.stamp_time = last_stamp[s];
      end else it = make_item(ACT_TICK, s, RK_OK, '0);
      add(it);
      // keep prediction-dependent counters fresh
      while (pending_items.size() > 2) @(posedge clk_i);
    end
  endtask

  initial begin
    in_item_t it;
    base_tmo = BaseReset;
    cap_tmo = CapReset;
    for (int s = 0; s < NS; s++) begin
      rel_ctr[s] = '0; unrel_ctr[s] = '0; tmo_val[s] = 16'(BaseReset);
      retry_cnt[s] = '0; q_head[s] = 0; q_cnt[s] = 0; last_stamp[s] = '0;
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // small timeouts so retries happen
    write_cfg(CFG_BASE, 15'd0);
    write_cfg(CFG_CAP, 15'd1);
    // directed: every action, receipt kind and special case
    add(make_item(ACT_RCPT, 0, RK_OK, '0));
    add(make_item(ACT_UNREL, 4, RK_OK, '0));
    it = make_item(ACT_UNREL, 7, RK_OK, '0);
    add(it);
    it = make_item(ACT_QUEUE, 1, RK_OK, '0);
    it.request_tag = '1; it.stamp_time = '1;
    add(it);
    add(make_item(ACT_QUEUE, 1, RK_OK, '0));
    add(make_item(ACT_TICK, 0, RK_OK, '0));
    add(make_item(ACT_TICK, 0, RK_OK, '0));
    add(make_item(ACT_RCPT, 1, rkind_e'(3'd7), '0));
    add(make_item(ACT_RCPT, 1, RK_OK, 16'h5555));
    add(make_item(ACT_RCPT, 1, RK_PKT_ERR, '0));
    add(make_item(ACT_RCPT, 1, RK_PAY_ERR, '0));
    it = make_item(ACT_RCPT, 1, RK_CORR, '0);
    it.stamp_valid = 1'b1; it.stamp_time = 64'h0123;
    add(it);
    it = make_item(ACT_RCPT, 1, RK_CORR, '0);
    it.stamp_valid = 1'b0; it.corrected_counter = 16'h0;
    add(it);
    it = make_item(ACT_RCPT, 1, RK_CORR, '0);
    it.stamp_valid = 1'b0; it.corrected_counter = 16'hFFFF;
    add(it);
    add(make_item(ACT_RCPT, 1, RK_OK, 16'hFFFF));
    for (int i = 0; i < QD + 1; i++) add(make_item(ACT_QUEUE, 2, RK_OK, '0));
    drain();

    write_cfg(CFG_BASE, 15'd3);
    write_cfg(CFG_CAP, 15'd20);
    random_phase(170);
    drain();
    write_cfg(CFG_BASE, 15'd32767);
    write_cfg(CFG_CAP, 15'd32767);
    random_phase(60);
    drain();
    write_cfg(CFG_BASE, 15'd1);
    write_cfg(CFG_CAP, 15'd4);
    random_phase(250);
    drain();

    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: FAIL");
    $finish;
  end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/arq_pkg.sv
rtl/core/arq_ram.sv
rtl/core/arq_front.sv
rtl/core/arq_back.sv
rtl/core/multi_stream_stop_and_wait_arq_core.sv
tb/sv/tb.sv
